// ===== hdl/tpcr_pkg.sv =====
package tpcr_pkg;

  // Stream framing
  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] STAMP_LEN     = 8'd4;
  localparam logic [7:0] LAST_POS_TS   = 8'd187;
  localparam logic [7:0] LAST_POS_M2TS = 8'd191;

  // Header flag masks
  localparam logic [7:0] AF_PRESENT_MASK = 8'h20;
  localparam logic [7:0] PCR_FLAG_MASK   = 8'h10;
  localparam logic [7:0] RAI_FLAG_MASK   = 8'h40;

  // PCR arithmetic: base * 300 + ext, in 27 MHz ticks
  localparam int unsigned PCR_W     = 42;
  localparam logic [8:0]  PCR_SCALE = 9'd300;

  // 250 ms at 27 MHz
  localparam logic [PCR_W-1:0] MAX_TICKS_RESET = 42'd6750000;

  localparam int unsigned        BLK_W   = 20;
  localparam logic [BLK_W-1:0]   BLK_MAX = 20'hFFFFF;

  localparam int unsigned COUNT_WIDTH_DEFAULT = 20;

  // Register map: index is paddr[3]
  localparam logic REG_PACKET_FORMAT   = 1'b0;
  localparam logic REG_MAX_BLOCK_TICKS = 1'b1;

  typedef struct packed {
    logic             packet_format;
    logic [PCR_W-1:0] max_block_ticks;
  } cfg_t;

  // One finished packet, as captured by the parser
  typedef struct packed {
    logic        sync_bad;
    logic [31:0] arrival;
    logic        pcr_here;
    logic [32:0] prog_base;
    logic [8:0]  pcr_ext;
  } pkt_rec_t;

  // Packet with the PCR already scaled to ticks
  typedef struct packed {
    logic             sync_bad;
    logic [31:0]      arrival;
    logic             pcr_here;
    logic [PCR_W-1:0] pcr;
  } blk_rec_t;

endpackage

// ===== hdl/tpcr_if.sv =====
interface tpcr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tpcr_result_if;
  logic        valid;
  logic        ready;
  logic        sync_error;
  logic [31:0] arrival_time;
  logic        has_pcr;
  logic        first_pcr;
  logic [41:0] pcr_value;
  logic [41:0] delta_ticks;
  logic [19:0] block_packets;
  logic        block_ok;

  modport source (output valid, output sync_error, output arrival_time, output has_pcr,
                  output first_pcr, output pcr_value, output delta_ticks,
                  output block_packets, output block_ok, input ready);
  modport sink   (input valid, input sync_error, input arrival_time, input has_pcr,
                  input first_pcr, input pcr_value, input delta_ticks,
                  input block_packets, input block_ok, output ready);
endinterface

// ===== hdl/tpcr_parser.sv =====
module tpcr_parser
  import tpcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  tpcr_byte_if.sink    stream,
  output logic         rec_valid,
  input  logic         rec_ready,
  output pkt_rec_t     rec
);

  logic [7:0]  byte_position;
  logic [23:0] header_flags;
  logic [47:0] pcr_bytes;
  logic [31:0] stamp_bytes;
  logic        sync_seen_bad;

  logic [7:0]  byte_position_next;
  logic [23:0] header_flags_next;
  logic [47:0] pcr_bytes_next;
  logic [31:0] stamp_bytes_next;
  logic        sync_seen_bad_next;

  logic [7:0]  last_pos;
  logic [7:0]  ts_pos;
  logic        in_stamp;
  logic        is_last;
  logic        take;
  logic        pcr_here;

  always_comb begin
    last_pos = cfg.packet_format ? LAST_POS_M2TS : LAST_POS_TS;
    in_stamp = cfg.packet_format && (byte_position < STAMP_LEN);
    ts_pos   = cfg.packet_format ? (byte_position - STAMP_LEN) : byte_position;
    is_last  = (byte_position >= last_pos);

    stamp_bytes_next   = stamp_bytes;
    sync_seen_bad_next = sync_seen_bad;
    header_flags_next  = header_flags;
    pcr_bytes_next     = pcr_bytes;
    if (in_stamp) begin
      stamp_bytes_next = {stamp_bytes[23:0], stream.data_byte};
    end else if (ts_pos == 8'd0) begin
      sync_seen_bad_next = (stream.data_byte != SYNC_BYTE);
    end else if (ts_pos >= 8'd3 && ts_pos <= 8'd5) begin
      header_flags_next = {header_flags[15:0], stream.data_byte};
    end else if (ts_pos >= 8'd6 && ts_pos <= 8'd11) begin
      pcr_bytes_next = {pcr_bytes[39:0], stream.data_byte};
    end

    byte_position_next = is_last ? 8'd0 : byte_position + 8'd1;

    // adaptation field present, nonzero length, PCR flag, no random access
    pcr_here = ((header_flags_next[23:16] & AF_PRESENT_MASK) != 8'd0)
            && (header_flags_next[15:8] != 8'd0)
            && ((header_flags_next[7:0] & PCR_FLAG_MASK) != 8'd0)
            && ((header_flags_next[7:0] & RAI_FLAG_MASK) == 8'd0);
  end

  // Hold the stream only on a packet end that cannot hand its record on
  assign stream.ready = !is_last || !rec_valid || rec_ready;
  assign take         = stream.valid && stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      header_flags  <= 24'd0;
      pcr_bytes     <= 48'd0;
      stamp_bytes   <= 32'd0;
      sync_seen_bad <= 1'b0;
    end else if (take) begin
      byte_position <= byte_position_next;
      header_flags  <= header_flags_next;
      pcr_bytes     <= pcr_bytes_next;
      stamp_bytes   <= stamp_bytes_next;
      sync_seen_bad <= sync_seen_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (take && is_last) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_last) begin
      rec.sync_bad  <= sync_seen_bad_next;
      rec.arrival   <= cfg.packet_format ? stamp_bytes_next : 32'd0;
      rec.pcr_here  <= pcr_here;
      rec.prog_base <= pcr_bytes_next[47:15];
      rec.pcr_ext   <= pcr_bytes_next[8:0];
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LAST_POS_M2TS)
    else $error("byte position past the end of an M2TS packet");

  a_last_gives_record: assert property (@(posedge clk) disable iff (rst)
    (take && is_last) |=> (rec_valid && byte_position == 8'd0))
    else $error("packet end did not produce a record");

endmodule

// ===== hdl/tpcr_pcr_calc.sv =====
module tpcr_pcr_calc
  import tpcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     rec_valid,
  output logic     rec_ready,
  input  pkt_rec_t rec,
  output logic     blk_valid,
  input  logic     blk_ready,
  output blk_rec_t blk
);

  logic [PCR_W-1:0] pcr_ticks;

  // base * 300 + ext; the largest value still fits in 42 bits
  assign pcr_ticks = PCR_W'(rec.prog_base) * PCR_W'(PCR_SCALE) + PCR_W'(rec.pcr_ext);
  assign rec_ready = !blk_valid || blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
    end else if (rec_ready) begin
      blk_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      blk.sync_bad <= rec.sync_bad;
      blk.arrival  <= rec.arrival;
      blk.pcr_here <= rec.pcr_here;
      blk.pcr      <= rec.pcr_here ? pcr_ticks : '0;
    end
  end

endmodule

// ===== hdl/tpcr_tracker.sv =====
module tpcr_tracker
  import tpcr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          blk_valid,
  output logic          blk_ready,
  input  blk_rec_t      blk,
  tpcr_result_if.source result
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > BLK_W) ? COUNT_WIDTH : BLK_W;

  logic [PCR_W-1:0]       last_pcr;
  logic                   have_pcr;
  logic [COUNT_WIDTH-1:0] packet_count;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CMP_W-1:0]       count_wide;
  logic [BLK_W-1:0]       blk_packets;
  logic [PCR_W-1:0]       delta;
  logic                   first;
  logic                   load;

  always_comb begin
    count_inc   = (packet_count == '1) ? packet_count : packet_count + COUNT_WIDTH'(1);
    count_wide  = CMP_W'(count_inc);
    blk_packets = (count_wide > CMP_W'(BLK_MAX)) ? BLK_MAX : BLK_W'(count_wide);
    first       = !have_pcr;
    delta       = first ? '0 : blk.pcr - last_pcr;
  end

  assign blk_ready = !result.valid || result.ready;
  assign load      = blk_valid && blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pcr     <= '0;
      have_pcr     <= 1'b0;
      packet_count <= '0;
    end else if (load) begin
      if (blk.pcr_here) begin
        last_pcr     <= blk.pcr;
        have_pcr     <= 1'b1;
        packet_count <= '0;
      end else begin
        packet_count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (blk_ready) begin
      result.valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.sync_error    <= blk.sync_bad;
      result.arrival_time  <= blk.arrival;
      result.has_pcr       <= blk.pcr_here;
      result.first_pcr     <= blk.pcr_here && first;
      result.pcr_value     <= blk.pcr;
      result.delta_ticks   <= blk.pcr_here ? delta : '0;
      result.block_packets <= blk.pcr_here ? blk_packets : '0;
      result.block_ok      <= blk.pcr_here && !first && (delta <= cfg.max_block_ticks);
    end
  end

  a_first_not_ok: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.first_pcr && result.block_ok))
    else $error("first PCR flagged as a valid block");

  a_no_pcr_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.has_pcr) |->
      (result.pcr_value == '0 && result.block_packets == '0 && !result.first_pcr))
    else $error("PCR fields set on a packet without PCR");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (load && blk.pcr_here) |=> (packet_count == '0 && have_pcr))
    else $error("block state not restarted after a PCR packet");

endmodule

// ===== hdl/ts_pcr_block_extractor.sv =====
// Transport stream PCR block extractor: one byte per clock in, one result per packet out.
// Throughput: one byte transfer every cycle; results never stall the byte side except on
//   a packet's last byte while three finished packets are still held downstream.
// Result path: after the transfer of a packet's last byte, the result is registered in the
//   parser record register, the PCR scaling register and the result register, in that order.
// Reset (rst, synchronous): packet position, PCR history and counters clear; registers
//   return to 188-byte TS format and a 6750000-tick block limit. No clearing pass.
module ts_pcr_block_extractor
  import tpcr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  tpcr_byte_if.sink     stream,
  tpcr_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  cfg_t     cfg;
  logic     cfg_write;

  logic     rec_valid;
  logic     rec_ready;
  pkt_rec_t rec;

  logic     blk_valid;
  logic     blk_ready;
  blk_rec_t blk;

  // ---------------------------------------------------------------------------
  // Configuration registers. Register index is paddr[3] (8-byte spacing); the
  // low address bits are ignored. Writes land in the access phase.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packet_format   <= 1'b0;
      cfg.max_block_ticks <= MAX_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_PACKET_FORMAT:   cfg.packet_format   <= pwdata[0];
        REG_MAX_BLOCK_TICKS: cfg.max_block_ticks <= pwdata[PCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_PACKET_FORMAT:   prdata = {63'd0, cfg.packet_format};
      REG_MAX_BLOCK_TICKS: prdata = {{(64-PCR_W){1'b0}}, cfg.max_block_ticks};
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage 1: track the byte position, capture the timestamp, sync byte,
  // header flags and PCR bytes; hand off one record at each packet end.
  // ---------------------------------------------------------------------------
  tpcr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stream    (stream),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: scale the PCR base to 27 MHz ticks (constant multiply by 300).
  // ---------------------------------------------------------------------------
  tpcr_pcr_calc u_pcr_calc (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: delta to the previous PCR, limit check, saturating packet count;
  // the result register here also decouples the output side.
  // ---------------------------------------------------------------------------
  tpcr_tracker #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .result    (result)
  );

endmodule

// ===== tb/ts_pcr_block_extractor_tb.sv =====
module ts_pcr_block_extractor_tb;
  import tpcr_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The long receiver hold-off is the slowest stretch of a correct run.
  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE_TICKS = 4;
  // Random packets per register setting; the hold-off setting needs enough
  // packets to fill every stage and stall the stream.
  localparam int RAND_PACKETS = 2;
  localparam int HOLD_PACKETS = 4;

  // One packet result, laid out as the result channel carries it
  typedef struct packed {
    logic             sync_error;
    logic [31:0]      arrival_time;
    logic             has_pcr;
    logic             first_pcr;
    logic [PCR_W-1:0] pcr_value;
    logic [PCR_W-1:0] delta_ticks;
    logic [BLK_W-1:0] block_packets;
    logic             block_ok;
  } pcr_report_t;

  // One packet of stimulus. len of zero means a whole packet of the current
  // format; other lengths cut it short or run it long to break the alignment.
  typedef struct packed {
    logic             set_cfg;
    logic             fmt;
    logic [PCR_W-1:0] limit;
    logic [8:0]       len;
    logic [31:0]      stamp;
    logic [7:0]       sync;
    logic [7:0]       b3;
    logic [7:0]       b4;
    logic [7:0]       b5;
    logic [47:0]      pcr_field;
    logic             typed;
    pcr_report_t      want;
  } pkt_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  tpcr_byte_if   byte_bus ();
  tpcr_result_if rep_bus ();

  ts_pcr_block_extractor dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (byte_bus),
    .result  (rep_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the register file, as the predictor sees it
  logic             cur_fmt   = 1'b0;
  logic [PCR_W-1:0] cur_limit = MAX_TICKS_RESET;

  // Shadow of the parser and PCR history
  logic [7:0]       pkt_pos    = '0;
  logic [23:0]      hdr_acc    = '0;
  logic [47:0]      pcr_acc    = '0;
  logic [31:0]      stamp_acc  = '0;
  logic             sync_bad   = 1'b0;
  logic [PCR_W-1:0] prev_pcr   = '0;
  logic             pcr_seen   = 1'b0;
  logic [BLK_W-1:0] blk_count  = '0;

  pcr_report_t pcr_reports_due [$];
  pcr_report_t head;
  pkt_row_t    plan [$];

  logic [32:0] rand_base     = '0;
  int unsigned feed_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  logic        hold_request  = 1'b0;
  int          mismatches    = 0;
  int          quiet_cycles  = 0;

  // Advance the parser shadow by one transferred byte; at a packet's last byte
  // raise done and work out the report the block must give for that packet.
  task automatic advance_parser(input logic [7:0] b, output logic done,
                                output pcr_report_t rep);
    logic [7:0]       lead;
    logic [7:0]       last;
    logic [7:0]       t;
    logic             pcr_here;
    logic [PCR_W-1:0] ticks;
    lead = cur_fmt ? STAMP_LEN : 8'd0;
    last = cur_fmt ? LAST_POS_M2TS : LAST_POS_TS;
    rep  = '0;
    done = 1'b0;
    if (pkt_pos < lead) begin
      stamp_acc = {stamp_acc[23:0], b};
    end else begin
      t = pkt_pos - lead;
      if (t == 8'd0)
        sync_bad = (b != SYNC_BYTE);
      else if (t >= 8'd3 && t <= 8'd5)
        hdr_acc = {hdr_acc[15:0], b};
      else if (t >= 8'd6 && t <= 8'd11)
        pcr_acc = {pcr_acc[39:0], b};
    end
    // A byte at or past the last position ends the packet, even right after
    // a format change shortened it.
    if (pkt_pos < last) begin
      pkt_pos = pkt_pos + 8'd1;
    end else begin
      pkt_pos  = 8'd0;
      done     = 1'b1;
      pcr_here = ((hdr_acc[23:16] & AF_PRESENT_MASK) != 8'd0) &&
                 (hdr_acc[15:8] != 8'd0) &&
                 ((hdr_acc[7:0] & PCR_FLAG_MASK) != 8'd0) &&
                 ((hdr_acc[7:0] & RAI_FLAG_MASK) == 8'd0);
      if (blk_count != BLK_MAX)
        blk_count = blk_count + 1'b1;
      rep.sync_error   = sync_bad;
      rep.arrival_time = cur_fmt ? stamp_acc : 32'd0;
      if (pcr_here) begin
        // base is the top 33 bits, extension the low 9; six reserved bits between
        ticks = PCR_W'(pcr_acc[47:15]) * PCR_W'(PCR_SCALE) + PCR_W'(pcr_acc[8:0]);
        rep.has_pcr       = 1'b1;
        rep.first_pcr     = !pcr_seen;
        rep.pcr_value     = ticks;
        rep.block_packets = blk_count;
        if (pcr_seen) begin
          rep.delta_ticks = ticks - prev_pcr;
          rep.block_ok    = (rep.delta_ticks <= cur_limit);
        end
        prev_pcr  = ticks;
        pcr_seen  = 1'b1;
        blk_count = '0;
      end
    end
  endtask

  function automatic pcr_report_t rpt(logic sync_error, logic [31:0] arrival,
                                      logic has, logic first, logic [PCR_W-1:0] pcr,
                                      logic [PCR_W-1:0] delta, logic [BLK_W-1:0] blk,
                                      logic ok);
    return '{sync_error, arrival, has, first, pcr, delta, blk, ok};
  endfunction

  function automatic pkt_row_t mk_row(logic set_cfg, logic fmt, logic [PCR_W-1:0] limit,
                                      logic [8:0] len, logic [31:0] stamp,
                                      logic [7:0] sync, logic [7:0] b3, logic [7:0] b4,
                                      logic [7:0] b5, logic [47:0] pcr_field,
                                      logic typed, pcr_report_t want);
    return '{set_cfg, fmt, limit, len, stamp, sync, b3, b4, b5, pcr_field, typed, want};
  endfunction

  // Byte idx of a packet laid out in the current format; PID bytes and
  // payload are random.
  function automatic logic [7:0] row_byte(pkt_row_t p, int idx);
    int t;
    t = idx - (cur_fmt ? int'(STAMP_LEN) : 0);
    if (t < 0)
      return p.stamp[8 * (3 - idx) +: 8];
    if (t == 0)
      return p.sync;
    if (t == 3)
      return p.b3;
    if (t == 4)
      return p.b4;
    if (t == 5)
      return p.b5;
    if (t >= 6 && t <= 11)
      return p.pcr_field[8 * (11 - t) +: 8];
    return 8'($urandom);
  endfunction

  // Mostly well-formed PCR packets with PCRs that walk forward by amounts on
  // both sides of the block limit; the rest is noise and packets of the wrong length.
  function automatic pkt_row_t rand_row();
    pkt_row_t p;
    p       = '0;
    p.stamp = $urandom;
    p.sync  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SYNC_BYTE;
    p.b3    = 8'($urandom);
    if ($urandom_range(0, 3) != 0)
      p.b3 = p.b3 | AF_PRESENT_MASK;
    p.b4 = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    p.b5 = 8'($urandom);
    if ($urandom_range(0, 4) != 0)
      p.b5 = (p.b5 | PCR_FLAG_MASK) & ~RAI_FLAG_MASK;
    if ($urandom_range(0, 9) == 0)
      rand_base = {$urandom, 1'($urandom)};
    else
      rand_base = rand_base + 33'($urandom_range(0, 25000));
    p.pcr_field = {rand_base, 6'($urandom),
                   ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 299))};
    if ($urandom_range(0, 19) == 0)
      p.len = 9'($urandom_range(1, 250));
    return p;
  endfunction

  // Offer one byte until it is transferred, idling first at random. Called and
  // left at a falling edge; valid stays high into the next call.
  task automatic send_byte(input logic [7:0] b, input logic use_typed,
                           input pcr_report_t typed_rep);
    logic        done;
    pcr_report_t rep;
    while ($urandom_range(0, 99) < feed_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    advance_parser(b, done, rep);
    if (done)
      pcr_reports_due.push_back(use_typed ? typed_rep : rep);
    @(negedge clk);
  endtask

  task automatic send_packet(input pkt_row_t p);
    int n;
    n = (p.len != 0) ? int'(p.len) :
        (cur_fmt ? int'(LAST_POS_M2TS) + 1 : int'(LAST_POS_TS) + 1);
    for (int i = 0; i < n; i++)
      send_byte(row_byte(p, i), p.typed, p.want);
  endtask

  // Finish a partly sent packet with payload so the next one starts aligned
  task automatic realign();
    while (pkt_pos != 8'd0)
      send_byte(8'($urandom), 1'b0, '0);
  endtask

  // Hold the stream until every packet result is in, then let the last
  // partial-packet bytes settle inside the block.
  task automatic wait_drained();
    byte_bus.valid <= 1'b0;
    while (pcr_reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase sees pready.
  task automatic reg_write(input logic sel, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_PACKET_FORMAT)
      cur_fmt = val[0];
    else
      cur_limit = val[PCR_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_config(input logic fmt, input logic [PCR_W-1:0] limit);
    wait_drained();
    reg_write(REG_PACKET_FORMAT, 64'(fmt));
    reg_write(REG_MAX_BLOCK_TICKS, 64'(limit));
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every result transfer with the oldest report still due
  always @(posedge clk) begin
    if (!rst && rep_bus.valid && rep_bus.ready) begin
      if (pcr_reports_due.size() == 0) begin
        $display("%0t: packet result, expected none, got pcr %0h", $time, rep_bus.pcr_value);
        mismatches++;
      end else begin
        head = pcr_reports_due.pop_front();
        check_field("sync_error", 64'(head.sync_error), 64'(rep_bus.sync_error));
        check_field("arrival_time", 64'(head.arrival_time), 64'(rep_bus.arrival_time));
        check_field("has_pcr", 64'(head.has_pcr), 64'(rep_bus.has_pcr));
        check_field("first_pcr", 64'(head.first_pcr), 64'(rep_bus.first_pcr));
        check_field("pcr_value", 64'(head.pcr_value), 64'(rep_bus.pcr_value));
        check_field("delta_ticks", 64'(head.delta_ticks), 64'(rep_bus.delta_ticks));
        check_field("block_packets", 64'(head.block_packets), 64'(rep_bus.block_packets));
        check_field("block_ok", 64'(head.block_ok), 64'(rep_bus.block_ok));
      end
    end
  end

  // Count cycles with no transfer on either channel; a hung block ends here
  always @(posedge clk) begin
    if ((byte_bus.valid && byte_bus.ready) || (rep_bus.valid && rep_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: drop ready at random, or hold it off for a long stretch on
  // request so the block fills up and stalls the byte stream.
  initial begin : result_sink
    int held;
    rep_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        for (held = 0; held < HOLD_CYCLES; held++) begin
          rep_bus.ready <= 1'b0;
          @(negedge clk);
        end
        hold_request = 1'b0;
      end
      rep_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin : stimulus
    int ph;
    int h;
    int k;
    int n_pkts;
    byte_bus.valid     = 1'b0;
    byte_bus.data_byte = 8'h00;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    feed_idle_pct      = 21;
    sink_idle_pct      = 66;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed packets, walked in order. Rows with typed results are the ones
    // whose report is plain from the packet; the rest go through the predictor.
    //                    cfg fmt limit len stamp sync b3 b4 b5 pcr field, typed, report
    // plain packet after reset
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h00, 8'h00, 8'h00, 48'h0,
                          1, '0));
    // bad sync, adaptation field with zero length
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h00, 8'h20, 8'h00, 8'h10, 48'h0,
                          1, rpt(1, 0, 0, 0, 0, 0, 0, 0)));
    // first PCR, largest base and extension, bad sync still reported
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'hFF, 8'h20, 8'h07, 8'h10, 48'hFFFF_FFFF_FFFF,
                          1, rpt(1, 0, 1, 1, 42'd2576980377811, 0, 20'd3, 0)));
    // zero PCR: delta wraps modulo 2^42
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'hFF, 8'hFF, 8'h10, 48'h0,
                          1, rpt(0, 0, 1, 0, 0, 42'd1821066133293, 20'd1, 0)));
    // random access set, adaptation field missing, PCR flag clear
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'h01, 8'h50, 48'h0,
                          1, '0));
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'hDF, 8'hFF, 8'hBF, 48'h0,
                          1, '0));
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'h01, 8'hEF, 48'h0,
                          1, '0));
    // delta exactly at the reset limit, reserved bits set
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'h01, 8'hBF,
                          {33'd22500, 6'h3F, 9'd0},
                          1, rpt(0, 0, 1, 0, 42'd6750000, 42'd6750000, 20'd4, 1)));
    // one tick over the limit
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'hB7, 8'h10,
                          {33'd45000, 6'd0, 9'd1},
                          1, rpt(0, 0, 1, 0, 42'd13500001, 42'd6750001, 20'd1, 0)));
    // zero limit: a zero delta passes, one tick fails
    plan.push_back(mk_row(1, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'h01, 8'h10,
                          {33'd45000, 6'd0, 9'd1},
                          1, rpt(0, 0, 1, 0, 42'd13500001, 0, 20'd1, 1)));
    plan.push_back(mk_row(0, 0, 0, 0, 32'h0, 8'h47, 8'h20, 8'h01, 8'h10,
                          {33'd45000, 6'd0, 9'd2},
                          1, rpt(0, 0, 1, 0, 42'd13500002, 42'd1, 20'd1, 0)));
    // M2TS with the largest limit and timestamp
    plan.push_back(mk_row(1, 1, {PCR_W{1'b1}}, 0, 32'hFFFF_FFFF, 8'h47, 8'h20, 8'h01, 8'h10,
                          {33'd0, 6'd0, 9'h1FF}, 0, '0));
    plan.push_back(mk_row(0, 1, 0, 0, 32'h0, 8'h47, 8'h00, 8'h00, 8'h00, 48'h0,
                          1, '0));
    plan.push_back(mk_row(0, 1, 0, 0, 32'h8000_0001, 8'h46, 8'h20, 8'h01, 8'h10,
                          48'h5A5A_A5A5_7E7E, 0, '0));
    // format change inside a packet: past the new last position, then at it
    plan.push_back(mk_row(0, 1, 0, 190, 32'h1234_5678, 8'h47, 8'h20, 8'h01, 8'h10,
                          48'h0000_0123_4567, 0, '0));
    plan.push_back(mk_row(1, 0, MAX_TICKS_RESET, 1, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00,
                          48'h0, 0, '0));
    plan.push_back(mk_row(1, 1, MAX_TICKS_RESET, 187, 32'h0A0B_0C0D, 8'h47, 8'h20, 8'h01,
                          8'h10, 48'h0001_2345_6789, 0, '0));
    plan.push_back(mk_row(1, 0, MAX_TICKS_RESET, 1, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          48'h0, 0, '0));

    foreach (plan[i]) begin
      if (plan[i].set_cfg)
        apply_config(plan[i].fmt, plan[i].limit);
      send_packet(plan[i]);
    end

    // Random packets in three idling modes, two register settings each
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          feed_idle_pct = 21;
          sink_idle_pct = 66;
        end
        1: begin
          feed_idle_pct = 66;
          sink_idle_pct = 21;
        end
        default: begin
          feed_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (h = 0; h < 2; h++) begin
        case (2 * ph + h)
          0: apply_config(1'b0, MAX_TICKS_RESET);
          1: apply_config(1'b1, PCR_W'($urandom_range(0, 7500000)));
          2: apply_config(1'b1, '0);
          3: apply_config(1'b0, {PCR_W{1'b1}});
          4: apply_config(1'b0, PCR_W'({$urandom, $urandom}));
          default: apply_config(1'b1, MAX_TICKS_RESET);
        endcase
        n_pkts = RAND_PACKETS;
        // Keep offering bytes through a long receiver hold-off
        if (ph == 2 && h == 0) begin
          hold_request = 1'b1;
          n_pkts       = HOLD_PACKETS;
        end
        for (k = 0; k < n_pkts; k++) begin
          // Pause the stream once until every report is in
          if (ph == 0 && h == 0 && k == 1)
            wait_drained();
          realign();
          send_packet(rand_row());
        end
      end
    end

    // Drain, give the block its latency, then report
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
